/* src/bitmap_rle_scanline_decoder_core_defines.svh */
// Assertion macros shared by the decoder RTL.
`ifndef BITMAP_RLE_SCANLINE_DECODER_CORE_DEFINES_SVH
`define BITMAP_RLE_SCANLINE_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define BMRLE_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMRLE_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`else

`define BMRLE_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)
`define BMRLE_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

/* src/bmrle_pkg.sv */
package bmrle_pkg;

   localparam int MAX_PATTERN_BYTES = 8;
   localparam int MAX_LINE_BYTES    = 8192;

   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int LINE_BYTES_W  = 14;
   localparam int PATTERN_LEN_W = 4;
   localparam int ROW_W         = 16;
   localparam int SEG_DATA_W    = 64;
   localparam int REPEAT_W      = 8;

   localparam logic [7:0] OP_LITERAL = 8'h80;
   localparam logic [7:0] OP_PATTERN = 8'h00;
   localparam logic [7:0] COUNT_MASK = 8'h7f;

   localparam logic [LINE_BYTES_W-1:0]  LINE_BYTES_RESET     = 14'd80;
   localparam logic [PATTERN_LEN_W-1:0] PATTERN_LENGTH_RESET = 4'd2;
   localparam logic [ROW_W-1:0]         ROW_TOTAL_RESET      = 16'd400;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_BYTES     = 2'd0,
      CSR_PATTERN_LENGTH = 2'd1,
      CSR_ROW_TOTAL      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_OPCODE    = 3'd0,
      PH_LIT_COUNT = 3'd1,
      PH_LIT_DATA  = 3'd2,
      PH_PAT_COUNT = 3'd3,
      PH_PAT_DATA  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [LINE_BYTES_W-1:0]  line_bytes;
      logic [PATTERN_LEN_W-1:0] pattern_length;
      logic [ROW_W-1:0]         row_total;
   } cfg_type;

   typedef struct packed {
      logic [SEG_DATA_W-1:0]    segment_data;
      logic [PATTERN_LEN_W-1:0] segment_length;
      logic [REPEAT_W-1:0]      repeat_count;
   } segment_type;

   typedef struct packed {
      logic row_end;
      logic image_end;
      logic row_overrun;
   } flags_type;

endpackage

/* src/bmrle_if.sv */
interface bmrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface bmrle_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [bmrle_pkg::SEG_DATA_W-1:0]      segment_data;
   logic [bmrle_pkg::PATTERN_LEN_W-1:0]   segment_length;
   logic [bmrle_pkg::REPEAT_W-1:0]        repeat_count;
   logic                                  row_end;
   logic                                  image_end;
   logic                                  row_overrun;

   modport source (output valid, output segment_data, output segment_length,
                   output repeat_count, output row_end, output image_end,
                   output row_overrun, input ready);
   modport sink   (input valid, input segment_data, input segment_length,
                   input repeat_count, input row_end, input image_end,
                   input row_overrun, output ready);
endinterface

interface bmrle_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bmrle_pkg::CSR_INDEX_W-1:0]   index;
   logic [bmrle_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/bmrle_csr.sv */
module bmrle_csr (
   input  logic               clock,
   input  logic               reset,
   bmrle_csr_if.sink          csr_ch,
   output bmrle_pkg::cfg_type cfg
);

   bmrle_pkg::cfg_type cfg_ff;
   bmrle_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // Decode the write; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (bmrle_pkg::csr_index_type'(csr_ch.index))
            bmrle_pkg::CSR_LINE_BYTES:
               cfg_in.line_bytes = csr_ch.data[bmrle_pkg::LINE_BYTES_W-1:0];
            bmrle_pkg::CSR_PATTERN_LENGTH:
               cfg_in.pattern_length = csr_ch.data[bmrle_pkg::PATTERN_LEN_W-1:0];
            bmrle_pkg::CSR_ROW_TOTAL:
               cfg_in.row_total = csr_ch.data[bmrle_pkg::ROW_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_bytes     <= bmrle_pkg::LINE_BYTES_RESET;
         cfg_ff.pattern_length <= bmrle_pkg::PATTERN_LENGTH_RESET;
         cfg_ff.row_total      <= bmrle_pkg::ROW_TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/bmrle_parse.sv */
module bmrle_parse #(
   parameter int MAX_PATTERN_BYTES = bmrle_pkg::MAX_PATTERN_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             stream_byte,
   input  bmrle_pkg::cfg_type     cfg,
   output logic                   seg_valid,
   output bmrle_pkg::segment_type seg
);

   localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam int PL_W  = bmrle_pkg::PATTERN_LEN_W;

   bmrle_pkg::phase_type phase_ff, phase_in;
   logic [7:0]           remaining_ff, remaining_in;
   logic [7:0]           repeats_ff, repeats_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [7:0]           store_ff [MAX_PATTERN_BYTES];

   logic [PL_W-1:0]                  pat_len;
   logic                             pat_last;
   logic [7:0]                       rem_dec;
   logic [bmrle_pkg::SEG_DATA_W-1:0] pattern_data;

   // Clamp the pattern length into 1..MAX_PATTERN_BYTES.
   always_comb begin
      if (cfg.pattern_length == '0) begin
         pat_len = PL_W'(1);
      end else if (cfg.pattern_length > PL_W'(MAX_PATTERN_BYTES)) begin
         pat_len = PL_W'(MAX_PATTERN_BYTES);
      end else begin
         pat_len = cfg.pattern_length;
      end
   end

   assign pat_last = (PL_W'(idx_ff) + PL_W'(1)) >= pat_len;
   assign rem_dec  = remaining_ff - 8'd1;

   // Current byte bypasses the store at its own slot.
   always_comb begin
      pattern_data = '0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         if (PL_W'(k) < pat_len) begin
            pattern_data[8*k +: 8] = (idx_ff == IDX_W'(k)) ? stream_byte : store_ff[k];
         end
      end
   end

   always_comb begin
      unique case (phase_ff)
         bmrle_pkg::PH_OPCODE: begin
            if (stream_byte == bmrle_pkg::OP_LITERAL) begin
               phase_in = bmrle_pkg::PH_LIT_COUNT;
            end else if (stream_byte == bmrle_pkg::OP_PATTERN) begin
               phase_in = bmrle_pkg::PH_PAT_COUNT;
            end else begin
               phase_in = bmrle_pkg::PH_OPCODE;
            end
         end
         bmrle_pkg::PH_LIT_COUNT:
            phase_in = (stream_byte == 8'd0) ? bmrle_pkg::PH_OPCODE : bmrle_pkg::PH_LIT_DATA;
         bmrle_pkg::PH_LIT_DATA:
            phase_in = (rem_dec == 8'd0) ? bmrle_pkg::PH_OPCODE : bmrle_pkg::PH_LIT_DATA;
         bmrle_pkg::PH_PAT_COUNT:
            phase_in = bmrle_pkg::PH_PAT_DATA;
         bmrle_pkg::PH_PAT_DATA:
            phase_in = pat_last ? bmrle_pkg::PH_OPCODE : bmrle_pkg::PH_PAT_DATA;
         default:
            phase_in = bmrle_pkg::PH_OPCODE;
      endcase
   end

   always_comb begin
      remaining_in       = remaining_ff;
      repeats_in         = repeats_ff;
      idx_in             = idx_ff;
      seg_valid          = 1'b0;
      seg.segment_data   = '0;
      seg.segment_length = PL_W'(1);
      seg.repeat_count   = 8'd1;
      unique case (phase_ff)
         bmrle_pkg::PH_OPCODE: begin
            if (stream_byte != bmrle_pkg::OP_LITERAL && stream_byte != bmrle_pkg::OP_PATTERN) begin
               seg_valid                = 1'b1;
               seg.segment_data[7:0]    = stream_byte[7] ? 8'hff : 8'h00;
               seg.repeat_count         = stream_byte & bmrle_pkg::COUNT_MASK;
            end
         end
         bmrle_pkg::PH_LIT_COUNT: begin
            remaining_in = stream_byte;
         end
         bmrle_pkg::PH_LIT_DATA: begin
            remaining_in          = rem_dec;
            seg_valid             = 1'b1;
            seg.segment_data[7:0] = stream_byte;
         end
         bmrle_pkg::PH_PAT_COUNT: begin
            repeats_in = stream_byte;
            idx_in     = '0;
         end
         bmrle_pkg::PH_PAT_DATA: begin
            if (pat_last) begin
               idx_in             = '0;
               seg_valid          = (repeats_ff != 8'd0);
               seg.segment_data   = pattern_data;
               seg.segment_length = pat_len;
               seg.repeat_count   = repeats_ff;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            seg_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bmrle_pkg::PH_OPCODE;
         remaining_ff <= '0;
         repeats_ff   <= '0;
         idx_ff       <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         repeats_ff   <= repeats_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && phase_ff == bmrle_pkg::PH_PAT_DATA) begin
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if (idx_ff == IDX_W'(k)) begin
               store_ff[k] <= stream_byte;
            end
         end
      end
   end

endmodule

/* src/bmrle_track.sv */
module bmrle_track #(
   parameter int MAX_LINE_BYTES = bmrle_pkg::MAX_LINE_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   seg_valid,
   input  bmrle_pkg::segment_type seg,
   input  bmrle_pkg::cfg_type     cfg,
   output bmrle_pkg::flags_type   flags
);

   localparam int COL_W  = $clog2(MAX_LINE_BYTES);
   localparam int ADV_W  = bmrle_pkg::PATTERN_LEN_W + bmrle_pkg::REPEAT_W;
   localparam int NEXT_W = COL_W + ADV_W;
   localparam int ROW_W  = bmrle_pkg::ROW_W;

   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [ADV_W-1:0]  advance;
   logic [NEXT_W-1:0] line_eff;
   logic [NEXT_W-1:0] col_next;
   logic [ROW_W:0]    total_eff;
   logic [ROW_W:0]    row_inc;

   assign advance  = ADV_W'(seg.segment_length) * ADV_W'(seg.repeat_count);
   assign col_next = NEXT_W'(column_ff) + NEXT_W'(advance);

   // Clamp the line width into 1..MAX_LINE_BYTES.
   always_comb begin
      if (cfg.line_bytes == '0) begin
         line_eff = NEXT_W'(1);
      end else if (NEXT_W'(cfg.line_bytes) > NEXT_W'(MAX_LINE_BYTES)) begin
         line_eff = NEXT_W'(MAX_LINE_BYTES);
      end else begin
         line_eff = NEXT_W'(cfg.line_bytes);
      end
   end

   assign total_eff = (cfg.row_total == '0) ? (ROW_W+1)'(1) : {1'b0, cfg.row_total};
   assign row_inc   = {1'b0, row_ff} + (ROW_W+1)'(1);

   always_comb begin
      flags.row_end     = (col_next >= line_eff);
      flags.row_overrun = (col_next > line_eff);
      flags.image_end   = flags.row_end && (row_inc >= total_eff);
      if (flags.row_end) begin
         column_in = '0;
         row_in    = flags.image_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
         column_in = col_next[COL_W-1:0];
         row_in    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else if (step && seg_valid) begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

/* src/bitmap_rle_scanline_decoder_core.sv */
// Run-length coded bitmap scan-line decoder.
// req_ch carries one compressed stream byte per request; rsp_ch carries one
// decoded segment (up to eight pixel bytes, their length, a repeat count and
// the row end, image end and row overrun flags). csr_ch writes the line
// width, pattern length and row total; it is always ready and must only be
// used while no request is in flight.
// Each request is latched in an input register and decoded by the parser and
// position tracker once the output register is empty or being drained; any
// segment lands in the output register, which drives rsp_ch.
// Throughput is one request per cycle unless the receiver stalls; opcode,
// count and partial pattern bytes produce no segment.
// When the receiver stalls, the output register holds its segment and the
// input register holds one more request; req_ch.ready drops only when both
// are full.
// Reset clears the parser to expect an opcode, zeroes column and row, empties
// both registers and restores line width 80, pattern length 2, row total 400.
`include "bitmap_rle_scanline_decoder_core_defines.svh"

module bitmap_rle_scanline_decoder_core #(
   parameter int MAX_PATTERN_BYTES = bmrle_pkg::MAX_PATTERN_BYTES,
   parameter int MAX_LINE_BYTES    = bmrle_pkg::MAX_LINE_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   bmrle_req_if.sink    req_ch,
   bmrle_rsp_if.source  rsp_ch,
   bmrle_csr_if.sink    csr_ch
);

   bmrle_pkg::cfg_type     cfg;
   bmrle_pkg::segment_type seg;
   bmrle_pkg::flags_type   flags;
   logic                   seg_valid;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   bmrle_pkg::segment_type rsp_seg_ff;
   bmrle_pkg::flags_type   rsp_flags_ff;

   logic advance;
   logic step;
   logic req_fire;

   // Advance when the output register is empty or being drained.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   bmrle_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bmrle_parse #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (in_byte_ff),
      .cfg         (cfg),
      .seg_valid   (seg_valid),
      .seg         (seg)
   );

   bmrle_track #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .seg_valid (seg_valid),
      .seg       (seg),
      .cfg       (cfg),
      .flags     (flags)
   );

   // Fill on a new request, drain when the request is decoded.
   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Load a fresh segment, or drop the old one once taken.
   always_comb begin
      if (step && seg_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.stream_byte;
      end
      if (step && seg_valid) begin
         rsp_seg_ff   <= seg;
         rsp_flags_ff <= flags;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.segment_data   = rsp_seg_ff.segment_data;
   assign rsp_ch.segment_length = rsp_seg_ff.segment_length;
   assign rsp_ch.repeat_count   = rsp_seg_ff.repeat_count;
   assign rsp_ch.row_end        = rsp_flags_ff.row_end;
   assign rsp_ch.image_end      = rsp_flags_ff.image_end;
   assign rsp_ch.row_overrun    = rsp_flags_ff.row_overrun;

   // A decoded segment must show up on the result channel next cycle.
   `BMRLE_ASSERT_NEXT(a_seg_lands, clock, reset, step && seg_valid, rsp_valid_ff, "decoded segment lost")
   // Image end and overrun only ever come with a row end.
   `BMRLE_ASSERT_IMPLY(a_image_row, clock, reset, rsp_valid_ff && rsp_flags_ff.image_end, rsp_flags_ff.row_end, "image end without row end")
   `BMRLE_ASSERT_IMPLY(a_overrun_row, clock, reset, rsp_valid_ff && rsp_flags_ff.row_overrun, rsp_flags_ff.row_end, "overrun without row end")
   // Segments never carry a zero repeat or zero length.
   `BMRLE_ASSERT_IMPLY(a_seg_nonzero, clock, reset, rsp_valid_ff, rsp_seg_ff.repeat_count != '0 && rsp_seg_ff.segment_length != '0, "empty segment")

endmodule

/* dv/bmrle_segment_checker.sv */
`timescale 1ns / 100ps

module bmrle_segment_checker (
   input  logic        clock,
   input  logic        reset,
   bmrle_req_if        req_ch,
   bmrle_rsp_if        rsp_ch,
   bmrle_csr_if        csr_ch,
   output int unsigned segments_pending,
   output int unsigned mismatch_count
);

   typedef struct packed {
      bmrle_pkg::segment_type seg;
      bmrle_pkg::flags_type   flags;
   } decoded_segment_type;

   decoded_segment_type segments_due[$];

   bmrle_pkg::cfg_type   cfg;
   bmrle_pkg::phase_type parse_state;
   logic [7:0] literal_left;
   logic [7:0] pattern_repeats;
   logic [7:0] pattern_bytes [bmrle_pkg::MAX_PATTERN_BYTES];
   logic [2:0] pattern_slot;
   logic [12:0] column;
   logic [15:0] row;

   initial begin
      mismatch_count   = 0;
      segments_pending = 0;
   end

   task automatic flag_mismatch(input string field, input logic [63:0] seen,
                                input logic [63:0] wanted);
      $display("segment mismatch on %s at %0t: got %0h, want %0h",
               field, $time, seen, wanted);
      mismatch_count++;
   endtask

   // Advance column and row by one segment and queue it with its flags.
   task automatic place_segment(input logic [63:0] data, input int len, input int reps);
      int line_w;
      int rows;
      int next_col;
      decoded_segment_type s;
      line_w = (cfg.line_bytes == 0) ? 1 :
               (cfg.line_bytes > bmrle_pkg::MAX_LINE_BYTES) ? bmrle_pkg::MAX_LINE_BYTES :
               int'(cfg.line_bytes);
      rows = (cfg.row_total == 0) ? 1 : int'(cfg.row_total);
      next_col = int'(column) + len * reps;
      s = '0;
      s.seg.segment_data   = data;
      s.seg.segment_length = len[bmrle_pkg::PATTERN_LEN_W-1:0];
      s.seg.repeat_count   = reps[bmrle_pkg::REPEAT_W-1:0];
      if (next_col >= line_w) begin
         s.flags.row_end     = 1'b1;
         s.flags.row_overrun = (next_col > line_w);
         column = '0;
         if (int'(row) + 1 >= rows) begin
            s.flags.image_end = 1'b1;
            row = '0;
         end else begin
            row = row + 16'd1;
         end
      end else begin
         column = next_col[12:0];
      end
      segments_due.push_back(s);
   endtask

   task automatic decode_byte(input logic [7:0] b);
      int span;
      logic [63:0] data;
      span = (cfg.pattern_length == 0) ? 1 :
             (cfg.pattern_length > bmrle_pkg::MAX_PATTERN_BYTES) ?
             bmrle_pkg::MAX_PATTERN_BYTES : int'(cfg.pattern_length);
      case (parse_state)
         bmrle_pkg::PH_LIT_COUNT: begin
            if (b == 8'd0) begin
               parse_state = bmrle_pkg::PH_OPCODE;
            end else begin
               literal_left = b;
               parse_state  = bmrle_pkg::PH_LIT_DATA;
            end
         end
         bmrle_pkg::PH_LIT_DATA: begin
            literal_left = literal_left - 8'd1;
            if (literal_left == 8'd0) parse_state = bmrle_pkg::PH_OPCODE;
            place_segment({56'd0, b}, 1, 1);
         end
         bmrle_pkg::PH_PAT_COUNT: begin
            pattern_repeats = b;
            pattern_slot    = '0;
            parse_state     = bmrle_pkg::PH_PAT_DATA;
         end
         bmrle_pkg::PH_PAT_DATA: begin
            pattern_bytes[pattern_slot] = b;
            if (int'(pattern_slot) + 1 < span) begin
               pattern_slot = pattern_slot + 3'd1;
            end else begin
               pattern_slot = '0;
               parse_state  = bmrle_pkg::PH_OPCODE;
               if (pattern_repeats != 8'd0) begin
                  data = '0;
                  for (int k = 0; k < span; k++) data[8*k +: 8] = pattern_bytes[k];
                  place_segment(data, span, int'(pattern_repeats));
               end
            end
         end
         default: begin
            parse_state = bmrle_pkg::PH_OPCODE;
            if (b == bmrle_pkg::OP_LITERAL) begin
               parse_state = bmrle_pkg::PH_LIT_COUNT;
            end else if (b == bmrle_pkg::OP_PATTERN) begin
               parse_state = bmrle_pkg::PH_PAT_COUNT;
            end else begin
               place_segment(b[7] ? 64'hff : 64'h00, 1, int'(b & bmrle_pkg::COUNT_MASK));
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      decoded_segment_type due;
      if (reset) begin
         segments_due.delete();
         cfg.line_bytes     = bmrle_pkg::LINE_BYTES_RESET;
         cfg.pattern_length = bmrle_pkg::PATTERN_LENGTH_RESET;
         cfg.row_total      = bmrle_pkg::ROW_TOTAL_RESET;
         parse_state     = bmrle_pkg::PH_OPCODE;
         literal_left    = '0;
         pattern_repeats = '0;
         pattern_slot    = '0;
         column          = '0;
         row             = '0;
         foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (segments_due.size() == 0) begin
               flag_mismatch("segment with none due", rsp_ch.segment_data, '0);
            end else begin
               due = segments_due.pop_front();
               if (rsp_ch.segment_data !== due.seg.segment_data)
                  flag_mismatch("segment_data", rsp_ch.segment_data, due.seg.segment_data);
               if (rsp_ch.segment_length !== due.seg.segment_length)
                  flag_mismatch("segment_length", 64'(rsp_ch.segment_length),
                                64'(due.seg.segment_length));
               if (rsp_ch.repeat_count !== due.seg.repeat_count)
                  flag_mismatch("repeat_count", 64'(rsp_ch.repeat_count),
                                64'(due.seg.repeat_count));
               if (rsp_ch.row_end !== due.flags.row_end)
                  flag_mismatch("row_end", 64'(rsp_ch.row_end), 64'(due.flags.row_end));
               if (rsp_ch.image_end !== due.flags.image_end)
                  flag_mismatch("image_end", 64'(rsp_ch.image_end), 64'(due.flags.image_end));
               if (rsp_ch.row_overrun !== due.flags.row_overrun)
                  flag_mismatch("row_overrun", 64'(rsp_ch.row_overrun),
                                64'(due.flags.row_overrun));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (bmrle_pkg::csr_index_type'(csr_ch.index))
               bmrle_pkg::CSR_LINE_BYTES:
                  cfg.line_bytes = csr_ch.data[bmrle_pkg::LINE_BYTES_W-1:0];
               bmrle_pkg::CSR_PATTERN_LENGTH:
                  cfg.pattern_length = csr_ch.data[bmrle_pkg::PATTERN_LEN_W-1:0];
               bmrle_pkg::CSR_ROW_TOTAL:
                  cfg.row_total = csr_ch.data[bmrle_pkg::ROW_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) decode_byte(req_ch.stream_byte);
      end
      segments_pending = segments_due.size();
   end

endmodule

/* dv/tb_bitmap_rle_scanline_decoder_core.sv */
`timescale 1ns / 100ps

module tb_bitmap_rle_scanline_decoder_core;

   // The register map has three entries; the fourth index must be ignored.
   localparam logic [bmrle_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int LONG_HOLD       = 80;
   localparam int SETTLE_CYCLES   = 4;

   // Receiver pacing styles, switched at random intervals.
   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_pace_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmrle_req_if req_ch ();
   bmrle_rsp_if rsp_ch ();
   bmrle_csr_if csr_ch ();

   int unsigned segments_pending;
   int unsigned mismatch_count;

   int items_sent   = 0;
   int burst_left   = 0;
   int pattern_span = int'(bmrle_pkg::PATTERN_LENGTH_RESET);
   bit hold_request = 1'b0;

   // Opening directed stream: solid runs at both colors and both count extremes,
   // a three-byte literal with extreme pixel values, an empty literal, a normal
   // pattern, a pattern with zero repeats and one with the maximum repeat count.
   logic [7:0] opening_bytes [23] = '{
      8'h81, 8'h7f, 8'h01, 8'hff,
      bmrle_pkg::OP_LITERAL, 8'h03, 8'h00, 8'hff, 8'ha5,
      bmrle_pkg::OP_LITERAL, 8'h00,
      bmrle_pkg::OP_PATTERN, 8'h02, 8'h12, 8'h34,
      bmrle_pkg::OP_PATTERN, 8'h00, 8'haa, 8'h55,
      bmrle_pkg::OP_PATTERN, 8'hff, 8'hde, 8'had
   };

   always #5 clock = ~clock;

   bitmap_rle_scanline_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bmrle_segment_checker segment_check (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_ch           (csr_ch),
      .segments_pending (segments_pending),
      .mismatch_count   (mismatch_count)
   );

   // Offer one stream byte from a falling edge, hold it until a rising edge
   // accepts it, then either keep the burst going or drop valid for a gap.
   task automatic send_stream_byte(input logic [7:0] value);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.stream_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Write one register, then drop valid and let a rising edge pass with valid low
   // so that back-to-back writes never drive valid twice in one step.
   task automatic write_register(input logic [bmrle_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [bmrle_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stop offering, wait until every predicted segment has left the block, then
   // idle for quiet_cycles so that requests that make no segment can finish.
   task automatic drain_and_settle(input int quiet_cycles);
      if (req_ch.valid) req_ch.valid <= 1'b0;
      while (segments_pending != 0) @(negedge clock);
      repeat (quiet_cycles) @(negedge clock);
   endtask

   // One random unit of stream: mostly well-formed runs with random content,
   // plus stray bytes that knock the parser out of step.
   task automatic send_random_run();
      int pick;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         // solid run, either color, any nonzero count
         send_stream_byte({1'($urandom_range(0, 1)), 7'($urandom_range(1, 127))});
      end else if (pick < 57) begin
         // literal string: empty now and then, rarely a long one
         count = $urandom_range(0, 99);
         count = (count < 5) ? 0 : (count < 8) ? $urandom_range(128, 255) :
                 $urandom_range(1, 16);
         send_stream_byte(bmrle_pkg::OP_LITERAL);
         send_stream_byte(8'(count));
         repeat (count) send_stream_byte(8'($urandom));
      end else if (pick < 88) begin
         // pattern run: zero and maximum repeat counts show up regularly
         count = $urandom_range(0, 99);
         count = (count < 8) ? 0 : (count < 16) ? 255 : $urandom_range(1, 60);
         send_stream_byte(bmrle_pkg::OP_PATTERN);
         send_stream_byte(8'(count));
         repeat (pattern_span) send_stream_byte(8'($urandom));
      end else begin
         send_stream_byte(8'($urandom));
      end
   endtask

   // Receiver: pace ready by a style that changes every so often; on request
   // hold it low for a long stretch so the output and input registers fill up
   // and req_ch.ready has to drop.
   initial begin
      rx_pace_type pace;
      int pace_left;
      int hold_left;
      rsp_ch.ready = 1'b0;
      pace      = RX_OPEN;
      pace_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (pace_left == 0) begin
               pace      = rx_pace_type'($urandom_range(0, 3));
               pace_left = $urandom_range(16, 160);
            end else begin
               pace_left--;
            end
            case (pace)
               RX_OPEN:   rsp_ch.ready <= 1'b1;
               RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ch.ready <= ~rsp_ch.ready;
            endcase
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [bmrle_pkg::CSR_DATA_W-1:0] line_data;
      logic [bmrle_pkg::CSR_DATA_W-1:0] span_data;
      logic [bmrle_pkg::CSR_DATA_W-1:0] rows_data;
      int phase_start;
      req_ch.valid       = 1'b0;
      req_ch.stream_byte = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;

      // Hold reset high from time zero and release it on a falling edge.
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) send_stream_byte(opening_bytes[i]);

      for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
         // Phase 0 runs on the reset settings; every later phase rewrites all
         // three registers while the block is idle.
         if (phase_no != 0) begin
            drain_and_settle(SETTLE_CYCLES);
            case (phase_no)
               1: begin
                  // narrowest line, one-byte pattern, one-row image
                  line_data = 16'd1;
                  span_data = 16'd1;
                  rows_data = 16'd1;
               end
               2: begin
                  // zeros: each acts as one
                  line_data = 16'd0;
                  span_data = 16'd0;
                  rows_data = 16'd0;
               end
               3: begin
                  // widest legal line, longest pattern, tallest image
                  line_data = 16'(bmrle_pkg::MAX_LINE_BYTES);
                  span_data = 16'(bmrle_pkg::MAX_PATTERN_BYTES);
                  rows_data = 16'hffff;
               end
               4: begin
                  // all ones: line and pattern clamp to their maximum
                  line_data = 16'hffff;
                  span_data = 16'hffff;
                  rows_data = 16'd2;
               end
               5: begin
                  line_data = 16'($urandom);
                  span_data = 16'($urandom);
                  rows_data = 16'($urandom);
               end
               default: begin
                  // small images so row and image ends come often
                  line_data = 16'($urandom_range(1, 48));
                  span_data = 16'($urandom_range(1, bmrle_pkg::MAX_PATTERN_BYTES));
                  rows_data = 16'($urandom_range(1, 6));
               end
            endcase
            write_register(bmrle_pkg::CSR_LINE_BYTES, line_data);
            write_register(bmrle_pkg::CSR_PATTERN_LENGTH, span_data);
            write_register(bmrle_pkg::CSR_ROW_TOTAL, rows_data);
            if (phase_no >= 5) write_register(CSR_SPARE_INDEX, 16'($urandom));
            pattern_span = (span_data[bmrle_pkg::PATTERN_LEN_W-1:0] == 0) ? 1 :
                           (span_data[bmrle_pkg::PATTERN_LEN_W-1:0] >
                            bmrle_pkg::MAX_PATTERN_BYTES) ?
                           bmrle_pkg::MAX_PATTERN_BYTES :
                           int'(span_data[bmrle_pkg::PATTERN_LEN_W-1:0]);
         end

         // Every result closes a row here, so a long receiver hold backs up
         // the block while the sender keeps pushing.
         if (phase_no == 1) hold_request = 1'b1;

         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) send_random_run();
      end

      drain_and_settle(2 * SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb_bitmap_rle_scanline_decoder_core OK");
      end else begin
         $display("tb_bitmap_rle_scanline_decoder_core NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("tb_bitmap_rle_scanline_decoder_core NOT OK");
      $finish;
   end

endmodule
